// File: rtl/gds_pkg.sv
`timescale 1ns / 1ps

package gds_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [13:0] set_year;
        logic [15:0] step_count;
    } gds_req_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic [21:0] serial_day;
        logic        error;
    } gds_res_t;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_BACK  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [26:0] RECIP_100 = 27'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_LPTMP,
        OP_LPCUR,
        OP_SETCHK,
        OP_FWD,
        OP_BACK,
        OP_SER1,
        OP_SER2,
        OP_EMIT
    } gds_op_t;

    typedef enum logic [1:0] {
        Y_CUR,
        Y_SET,
        Y_PREV
    } gds_ysel_t;

    typedef enum logic [2:0] {
        C_DISP,
        C_SEQ,
        C_JMP,
        C_LOOP,
        C_EMIT
    } gds_cond_t;

    typedef struct packed {
        gds_op_t    op;
        gds_ysel_t  ysel;
        gds_cond_t  cond;
        logic [3:0] target;
    } gds_uword_t;

    localparam logic [3:0] UA_IDLE    = 4'd0;
    localparam logic [3:0] UA_SET     = 4'd1;
    localparam logic [3:0] UA_SETLP   = 4'd2;
    localparam logic [3:0] UA_SETCHK  = 4'd3;
    localparam logic [3:0] UA_FWD     = 4'd4;
    localparam logic [3:0] UA_FWDMUL  = 4'd5;
    localparam logic [3:0] UA_FWDLP   = 4'd6;
    localparam logic [3:0] UA_BACK    = 4'd7;
    localparam logic [3:0] UA_BACKMUL = 4'd8;
    localparam logic [3:0] UA_BACKLP  = 4'd9;
    localparam logic [3:0] UA_SER     = 4'd10;
    localparam logic [3:0] UA_SER1    = 4'd11;
    localparam logic [3:0] UA_SER2    = 4'd12;
    localparam logic [3:0] UA_EMIT    = 4'd13;

    function automatic gds_uword_t ucode(input logic [3:0] addr);
        gds_uword_t w;
        w = '{op: OP_NOP, ysel: Y_CUR, cond: C_JMP, target: UA_IDLE};
        case (addr)
            UA_IDLE:    w = '{op: OP_NOP,    ysel: Y_CUR,  cond: C_DISP, target: UA_IDLE};
            UA_SET:     w = '{op: OP_MUL,    ysel: Y_SET,  cond: C_SEQ,  target: UA_IDLE};
            UA_SETLP:   w = '{op: OP_LPTMP,  ysel: Y_SET,  cond: C_SEQ,  target: UA_IDLE};
            UA_SETCHK:  w = '{op: OP_SETCHK, ysel: Y_SET,  cond: C_JMP,  target: UA_SER};
            UA_FWD:     w = '{op: OP_FWD,    ysel: Y_CUR,  cond: C_LOOP, target: UA_SER};
            UA_FWDMUL:  w = '{op: OP_MUL,    ysel: Y_CUR,  cond: C_SEQ,  target: UA_IDLE};
            UA_FWDLP:   w = '{op: OP_LPCUR,  ysel: Y_CUR,  cond: C_JMP,  target: UA_FWD};
            UA_BACK:    w = '{op: OP_BACK,   ysel: Y_CUR,  cond: C_LOOP, target: UA_SER};
            UA_BACKMUL: w = '{op: OP_MUL,    ysel: Y_CUR,  cond: C_SEQ,  target: UA_IDLE};
            UA_BACKLP:  w = '{op: OP_LPCUR,  ysel: Y_CUR,  cond: C_JMP,  target: UA_BACK};
            UA_SER:     w = '{op: OP_MUL,    ysel: Y_PREV, cond: C_SEQ,  target: UA_IDLE};
            UA_SER1:    w = '{op: OP_SER1,   ysel: Y_PREV, cond: C_SEQ,  target: UA_IDLE};
            UA_SER2:    w = '{op: OP_SER2,   ysel: Y_PREV, cond: C_SEQ,  target: UA_IDLE};
            UA_EMIT:    w = '{op: OP_EMIT,   ysel: Y_CUR,  cond: C_EMIT, target: UA_IDLE};
            default:    w = '{op: OP_NOP,    ysel: Y_CUR,  cond: C_JMP,  target: UA_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/gregorian_date_stepper.sv
`timescale 1ns / 1ps

// Channel   Signals                     Carries
// request   cmd_valid, cmd_stall, cmd   command, date to load, day count
// result    res_valid, res_stall, res   date, serial day number, error flag
//
// One request at a time. Set checks and loads the date; forward and back move it by the day
// stepper, which sets the rate: one day per cycle, pausing at each year boundary to update the
// leap flag. Every request ends by computing the serial day number into the result register.
// After reset the date is 1/1/0001. cmd_stall is high while a request is in work.
// A result held under res_stall stalls only the final step of the next request.

module gregorian_date_stepper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  gds_pkg::gds_req_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output gds_pkg::gds_res_t res
);
    import gds_pkg::*;

    logic [3:0]  upc_reg, upc_next;
    gds_req_t    cmd_reg, cmd_next;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  month_reg, month_next;
    logic [13:0] year_reg, year_next;
    logic        leap_reg, leap_next;
    logic        lp_reg, lp_next;
    logic [15:0] count_reg, count_next;
    logic        err_reg, err_next;
    logic [26:0] prod_reg, prod_next;
    logic [21:0] serial_reg, serial_next;
    logic        res_valid_reg, res_valid_next;
    gds_res_t    res_reg, res_next;

    gds_uword_t  uw;
    logic        accept;
    logic        done;
    logic        yrchg;
    logic        res_free;
    logic [13:0] yop;
    logic [7:0]  quot;
    logic [13:0] rem100;
    logic        lp;
    logic [4:0]  mlen_cur;
    logic [4:0]  mlen_set;
    logic        set_ok;
    logic [3:0]  disp;

    assign uw        = ucode(upc_reg);
    assign cmd_stall = (upc_reg != UA_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_free  = !res_valid_reg || !res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        case (uw.ysel)
            Y_SET:   yop = cmd_reg.set_year;
            Y_PREV:  yop = year_reg - 14'd1;
            default: yop = year_reg;
        endcase
        quot     = prod_reg[RECIP_SHIFT +: 8];
        rem100   = yop - 14'({6'd0, quot} * 14'd100);
        lp       = (yop[1:0] == 2'd0) && ((rem100 != 14'd0) || (quot[1:0] == 2'd0));
        mlen_cur = month_len(month_reg, leap_reg);
        mlen_set = month_len(cmd_reg.set_month, lp_reg);
        set_ok   = (cmd_reg.set_year >= 14'd1) && (cmd_reg.set_year <= YEAR_MAX)
                   && (cmd_reg.set_month >= 4'd1) && (cmd_reg.set_month <= 4'd12)
                   && (cmd_reg.set_day >= 5'd1) && (cmd_reg.set_day <= mlen_set);
        case (cmd.command)
            CMD_SET:  disp = UA_SET;
            CMD_FWD:  disp = UA_FWD;
            CMD_BACK: disp = UA_BACK;
            default:  disp = UA_SER;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        leap_next      = leap_reg;
        lp_next        = lp_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        prod_next      = prod_reg;
        serial_next    = serial_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        done           = 1'b0;
        yrchg          = 1'b0;

        case (uw.op)
            OP_NOP:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    count_next = cmd.step_count;
                    err_next   = 1'b0;
                end
            end
            OP_MUL:
            begin
                prod_next = {13'd0, yop} * RECIP_100;
            end
            OP_LPTMP:
            begin
                lp_next = lp;
            end
            OP_LPCUR:
            begin
                leap_next = lp;
            end
            OP_SETCHK:
            begin
                if (set_ok)
                begin
                    day_next   = cmd_reg.set_day;
                    month_next = cmd_reg.set_month;
                    year_next  = cmd_reg.set_year;
                    leap_next  = lp_reg;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            OP_FWD:
            begin
                if (count_reg == 16'd0)
                begin
                    done = 1'b1;
                end
                else if (day_reg < mlen_cur)
                begin
                    day_next   = day_reg + 5'd1;
                    count_next = count_reg - 16'd1;
                end
                else if (month_reg < 4'd12)
                begin
                    day_next   = 5'd1;
                    month_next = month_reg + 4'd1;
                    count_next = count_reg - 16'd1;
                end
                else if (year_reg >= YEAR_MAX)
                begin
                    err_next = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    day_next   = 5'd1;
                    month_next = 4'd1;
                    year_next  = year_reg + 14'd1;
                    count_next = count_reg - 16'd1;
                    yrchg      = 1'b1;
                end
            end
            OP_BACK:
            begin
                if (count_reg == 16'd0)
                begin
                    done = 1'b1;
                end
                else if (day_reg > 5'd1)
                begin
                    day_next   = day_reg - 5'd1;
                    count_next = count_reg - 16'd1;
                end
                else if (month_reg > 4'd1)
                begin
                    month_next = month_reg - 4'd1;
                    day_next   = month_len(month_reg - 4'd1, leap_reg);
                    count_next = count_reg - 16'd1;
                end
                else if (year_reg <= 14'd1)
                begin
                    err_next = 1'b1;
                    done     = 1'b1;
                end
                else
                begin
                    day_next   = 5'd31;
                    month_next = 4'd12;
                    year_next  = year_reg - 14'd1;
                    count_next = count_reg - 16'd1;
                    yrchg      = 1'b1;
                end
            end
            OP_SER1:
            begin
                serial_next = {8'd0, yop} * 22'd365;
            end
            OP_SER2:
            begin
                serial_next = serial_reg + 22'(yop >> 2) - 22'(quot) + 22'(quot >> 2)
                              + 22'(days_before(month_reg))
                              + 22'((month_reg > 4'd2) && leap_reg)
                              + 22'(day_reg) - 22'd1;
            end
            OP_EMIT:
            begin
                if (res_free)
                begin
                    res_next = '{out_day: day_reg, out_month: month_reg, out_year: year_reg,
                                 serial_day: serial_reg, error: err_reg};
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase

        case (uw.cond)
            C_DISP:  upc_next = accept ? disp : upc_reg;
            C_SEQ:   upc_next = upc_reg + 4'd1;
            C_JMP:   upc_next = uw.target;
            C_LOOP:  upc_next = done ? uw.target : (yrchg ? upc_reg + 4'd1 : upc_reg);
            C_EMIT:  upc_next = res_free ? uw.target : upc_reg;
            default: upc_next = UA_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_IDLE;
            cmd_reg       <= '0;
            day_reg       <= 5'd1;
            month_reg     <= 4'd1;
            year_reg      <= 14'd1;
            leap_reg      <= 1'b0;
            lp_reg        <= 1'b0;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            prod_reg      <= '0;
            serial_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cmd_reg       <= cmd_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            leap_reg      <= leap_next;
            lp_reg        <= lp_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            prod_reg      <= prod_next;
            serial_reg    <= serial_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    // The held date is always a real date within the supported range.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= 4'd1) && (month_reg <= 4'd12) && (day_reg >= 5'd1)
        && (year_reg >= 14'd1) && (year_reg <= YEAR_MAX))
        else $error("held date out of range");

    // Between requests the day fits the month under the cached leap flag.
    a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_IDLE) |-> (day_reg <= mlen_cur))
        else $error("day beyond month length");

    // A new result appears only from the final microcode step.
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(upc_reg == UA_EMIT))
        else $error("result raised outside the emit step");

    // Leaving the emit step means the result register took the result.
    a_emit_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_EMIT) && res_free |=> res_valid_reg && (upc_reg == UA_IDLE))
        else $error("emit step left without a result");

endmodule
